@@ rtl/timer_latency_statistics_defines.svh @@
// Assertion helpers used by the controller.
`ifndef TIMER_LATENCY_STATISTICS_DEFINES_SVH
`define TIMER_LATENCY_STATISTICS_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by another one in the next cycle.
`define TLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tls_pkg.sv @@
package tls_pkg;

  // Input item codes
  typedef enum logic [1:0] {
    ITEM_START  = 2'd0,
    ITEM_SAMPLE = 2'd1,
    ITEM_STOP   = 2'd2,
    ITEM_READ   = 2'd3
  } item_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_INTERIM = 2'd1,
    KIND_FINAL   = 2'd2,
    KIND_COUNT   = 2'd3
  } kind_e;

  // Histogram selection codes
  localparam logic [1:0] HSEL_MIN = 2'd0;
  localparam logic [1:0] HSEL_MAX = 2'd1;
  localparam logic [1:0] HSEL_AVG = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_PERIOD  = 3'd0;
  localparam logic [2:0] CFG_SPR     = 3'd1;
  localparam logic [2:0] CFG_WARMUP  = 3'd2;
  localparam logic [2:0] CFG_BUCKETS = 3'd3;
  localparam logic [2:0] CFG_BUCKET  = 3'd4;
  localparam logic [2:0] CFG_CPU     = 3'd5;

  // Configuration reset values
  localparam logic [30:0] RST_PERIOD  = 31'd1000000;
  localparam logic [19:0] RST_SPR     = 20'd1000;
  localparam logic [15:0] RST_WARMUP  = 16'd1;
  localparam logic [10:0] RST_BUCKETS = 11'd0;
  localparam logic [19:0] RST_BUCKET  = 20'd1000;
  localparam logic [11:0] RST_CPU     = 12'd500;

  localparam logic signed [31:0] INIT_MIN = 32'sd10000000;
  localparam logic signed [31:0] INIT_MAX = -32'sd10000000;
  localparam logic [63:0] START_OFFSET    = 64'd1000000;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] timestamp;
    logic [63:0] rearm_time;
    logic [1:0]  hist_select;
    logic [9:0]  hist_index;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] last_min_ns;
    logic signed [31:0] last_max_ns;
    logic signed [31:0] last_avg_ns;
    logic signed [31:0] overall_min_ns;
    logic signed [31:0] overall_max_ns;
    logic signed [31:0] overall_avg_ns;
    logic [31:0]        total_overruns;
    logic [31:0]        report_loops;
    logic [31:0]        hist_count;
  } out_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    DP_NONE,
    DP_CAPTURE,
    DP_CLEAR,
    DP_LAT,
    DP_DIV_CVT,
    DP_CVT_NS,
    DP_DIV_BIN,
    DP_BIN_RD,
    DP_BIN_WR,
    DP_DIV_SKIP,
    DP_SK_MUL,
    DP_SK_ADD,
    DP_COUNT,
    DP_DIV_AVG,
    DP_CW_KEEP,
    DP_CW_FIN,
    DP_DIV_STOP,
    DP_STOP_FIN,
    DP_RD,
    DP_RD_CAP,
    DP_RESP
  } dp_op_e;

  // Value under conversion and binning
  typedef enum logic [1:0] {
    JOB_DT  = 2'd0,
    JOB_MAX = 2'd1,
    JOB_MIN = 2'd2,
    JOB_SUM = 2'd3
  } job_e;

  typedef struct packed {
    dp_op_e op;
    job_e   job;
  } cmd_t;

  typedef struct packed {
    logic [1:0] item;
    logic       div_busy;
    logic       out_free;
    logic       hist_on;
    logic       in_warmup;
    logic       skip;
    logic       close_win;
    logic       clr_last;
  } sts_t;

  // Saturate a signed 64-bit value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

@@ rtl/timer_latency_statistics.sv @@
// Timer latency statistics: one transaction in flight, one result per transaction.
// Samples are binned (histograms on, warmup over) and skipped periods counted; a window
// close converts its values, binning them with histograms on, except in warmup. Stop
// forms the overall average, Read a histogram entry, Start sweeps the histograms.
// Divisions share one 64-step bit-serial divider. The next input is taken in the cycle
// after the result. Reset clears all statistics, then sweeps the histograms.
module timer_latency_statistics import tls_pkg::*; #(
  parameter int unsigned HIST_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  cmd_t cmd;
  sts_t sts;

  tls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tls_datapath #(.HIST_DEPTH(HIST_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

@@ rtl/tls_ram.sv @@
module tls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tls_div.sv @@
module tls_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] quot_o
);

  logic [63:0] rem_q, quo_q, dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [64:0] shifted;
  logic [64:0] diff;
  logic        ge;

  // One quotient bit per cycle, restoring form
  always_comb begin
    shifted = {rem_q, quo_q[63]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[63:0] : shifted[63:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

@@ rtl/tls_datapath.sv @@
module tls_datapath import tls_pkg::*; #(
  parameter int unsigned HIST_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  in_t         in_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output out_t        out_data_o,
  input  cmd_t        cmd_i,
  output sts_t        sts_o
);

  localparam int unsigned AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  // Configuration
  logic [30:0] period_q;
  logic [19:0] spr_q;
  logic [15:0] warmup_q;
  logic [10:0] buckets_q;
  logic [19:0] bucket_q;
  logic [11:0] cpu_q;

  // Statistics state
  logic [63:0]        next_rel_q, last_rearm_q;
  logic               warm_q;
  logic [19:0]        sc_q;
  logic signed [31:0] wmin_q, wmax_q;
  logic signed [63:0] wsum_q;
  logic [31:0]        wov_q;
  logic signed [31:0] best_q, worst_q;
  logic [63:0]        acc_q;
  logic [31:0]        ovt_q, loops_q;
  logic signed [31:0] kmin_q, kmax_q, kavg_q;

  // Working registers
  in_t                in_q;
  kind_e              kind_q;
  logic signed [31:0] dt_q, ns_q, mx_q, mn_q, savg_q;
  logic signed [63:0] sumns_q;
  logic               neg_q;
  logic [62:0]        prod_q;
  logic [AW-1:0]      bin_q, clr_q;
  logic [31:0]        cnt_q;
  logic               out_valid_q;
  out_t               out_q;

  // Derived values
  logic [30:0]        per;
  logic [19:0]        spr_nz, bucket_nz;
  logic [11:0]        cpu_nz;
  logic [31:0]        used, bin_full, idx_ext, ns_mag, loops_m1;
  logic [19:0]        sc_inc;
  logic signed [63:0] src_v, sq, sp;
  logic [63:0]        p1000, dvd, dvs, q_w, diff64;
  logic               div_start, div_busy;
  logic [31:0]        k_w;
  logic signed [31:0] kavg_n;
  logic [AW-1:0]      raddr, waddr;
  logic [2:0]         ram_we;
  logic [31:0]        wdata, rd_min, rd_max, rd_avg, rd_sel;
  logic               rd_ok;
  out_t               resp;

  always_comb begin
    per       = (period_q == '0) ? 31'd1 : period_q;
    spr_nz    = (spr_q == '0) ? 20'd1 : spr_q;
    bucket_nz = (bucket_q == '0) ? 20'd1 : bucket_q;
    cpu_nz    = (cpu_q == '0) ? 12'd1 : cpu_q;
    used      = ({21'd0, buckets_q} > HIST_DEPTH) ? 32'(HIST_DEPTH) : {21'd0, buckets_q};
    sc_inc    = sc_q + 20'd1;
    idx_ext   = {22'd0, in_q.hist_index};
    ns_mag    = ns_q[31] ? 32'd0 - ns_q : ns_q;
    loops_m1  = (loops_q > 32'd1) ? loops_q - 32'd1 : 32'd1;
    diff64    = in_q.timestamp - next_rel_q;
    k_w       = q_w[31:0];
  end

  // Select the value to convert
  always_comb begin
    case (cmd_i.job)
      JOB_DT:  src_v = {{32{dt_q[31]}}, dt_q};
      JOB_MAX: src_v = {{32{wmax_q[31]}}, wmax_q};
      JOB_MIN: src_v = {{32{wmin_q[31]}}, wmin_q};
      default: src_v = wsum_q;
    endcase
  end

  // Divider operands
  always_comb begin
    dvd       = '0;
    dvs       = 64'd1;
    div_start = 1'b0;
    case (cmd_i.op)
      DP_DIV_CVT: begin
        dvd       = src_v[63] ? 64'd0 - src_v : src_v;
        dvs       = {52'd0, cpu_nz};
        div_start = 1'b1;
      end
      DP_DIV_BIN: begin
        dvd       = {32'd0, ns_mag};
        dvs       = {44'd0, bucket_nz};
        div_start = 1'b1;
      end
      DP_DIV_SKIP: begin
        dvd       = {32'd0, dt_q - 32'sd1};
        dvs       = {33'd0, per};
        div_start = 1'b1;
      end
      DP_DIV_AVG: begin
        dvd       = sumns_q[63] ? 64'd0 - sumns_q : sumns_q;
        dvs       = {44'd0, spr_nz};
        div_start = 1'b1;
      end
      DP_DIV_STOP: begin
        dvd       = acc_q[63] ? 64'd0 - acc_q : acc_q;
        dvs       = {32'd0, loops_m1};
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  tls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .quot_o     (q_w)
  );

  // Restore sign, scale by 1000 as shifts and adds
  always_comb begin
    sq     = neg_q ? -$signed(q_w) : $signed(q_w);
    p1000  = (q_w << 10) - (q_w << 5) + (q_w << 3);
    sp     = neg_q ? -$signed(p1000) : $signed(p1000);
    kavg_n = sat32(sq);
  end

  // Bin clamp and histogram memory access
  always_comb begin
    bin_full = (q_w >= {32'd0, used}) ? used - 32'd1 : q_w[31:0];
    raddr    = (cmd_i.op == DP_BIN_RD) ? bin_full[AW-1:0] : idx_ext[AW-1:0];
    waddr    = (cmd_i.op == DP_CLEAR) ? clr_q : bin_q;
    ram_we   = 3'b000;
    case (cmd_i.job)
      JOB_MAX: rd_sel = rd_max;
      JOB_MIN: rd_sel = rd_min;
      default: rd_sel = rd_avg;
    endcase
    wdata = (rd_sel == 32'hffffffff) ? rd_sel : rd_sel + 32'd1;
    if (cmd_i.op == DP_CLEAR) begin
      ram_we = 3'b111;
      wdata  = '0;
    end else if (cmd_i.op == DP_BIN_WR) begin
      case (cmd_i.job)
        JOB_MAX: ram_we[HSEL_MAX] = 1'b1;
        JOB_MIN: ram_we[HSEL_MIN] = 1'b1;
        default: ram_we[HSEL_AVG] = 1'b1;
      endcase
    end
    rd_ok = ({22'd0, in_q.hist_index} < HIST_DEPTH) &&
            (in_q.hist_select == HSEL_MIN || in_q.hist_select == HSEL_MAX ||
             in_q.hist_select == HSEL_AVG);
  end

  tls_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_min_ram (
    .clk_i (clk_i), .we_i (ram_we[HSEL_MIN]), .waddr_i (waddr), .wdata_i (wdata),
    .raddr_i (raddr), .rdata_o (rd_min)
  );

  tls_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_max_ram (
    .clk_i (clk_i), .we_i (ram_we[HSEL_MAX]), .waddr_i (waddr), .wdata_i (wdata),
    .raddr_i (raddr), .rdata_o (rd_max)
  );

  tls_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_avg_ram (
    .clk_i (clk_i), .we_i (ram_we[HSEL_AVG]), .waddr_i (waddr), .wdata_i (wdata),
    .raddr_i (raddr), .rdata_o (rd_avg)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= RST_PERIOD;
      spr_q     <= RST_SPR;
      warmup_q  <= RST_WARMUP;
      buckets_q <= RST_BUCKETS;
      bucket_q  <= RST_BUCKET;
      cpu_q     <= RST_CPU;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PERIOD:  period_q  <= cfg_data_i;
        CFG_SPR:     spr_q     <= cfg_data_i[19:0];
        CFG_WARMUP:  warmup_q  <= cfg_data_i[15:0];
        CFG_BUCKETS: buckets_q <= cfg_data_i[10:0];
        CFG_BUCKET:  bucket_q  <= cfg_data_i[19:0];
        CFG_CPU:     cpu_q     <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Statistics and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_rel_q   <= '0;
      last_rearm_q <= '0;
      warm_q       <= 1'b1;
      sc_q         <= '0;
      wmin_q       <= INIT_MIN;
      wmax_q       <= INIT_MAX;
      wsum_q       <= '0;
      wov_q        <= '0;
      best_q       <= INIT_MIN;
      worst_q      <= INIT_MAX;
      acc_q        <= '0;
      ovt_q        <= '0;
      loops_q      <= 32'd1;
      kmin_q       <= '0;
      kmax_q       <= '0;
      kavg_q       <= '0;
      kind_q       <= KIND_ACK;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once the transaction is taken
      if (cmd_i.op == DP_RESP) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        DP_CAPTURE: begin
          kind_q <= (in_data_i.op == ITEM_STOP) ? KIND_FINAL :
                    (in_data_i.op == ITEM_READ) ? KIND_COUNT : KIND_ACK;
          case (in_data_i.op)
            ITEM_START: begin
              last_rearm_q <= in_data_i.timestamp + START_OFFSET;
              next_rel_q   <= in_data_i.timestamp + START_OFFSET + {33'd0, per};
              best_q       <= INIT_MIN;
              worst_q      <= INIT_MAX;
              acc_q        <= '0;
              loops_q      <= 32'd1;
              ovt_q        <= '0;
              warm_q       <= 1'b1;
              wmin_q       <= INIT_MIN;
              wmax_q       <= INIT_MAX;
              wsum_q       <= '0;
              wov_q        <= '0;
              sc_q         <= '0;
            end
            default: ;
          endcase
        end
        DP_CLEAR: begin
          clr_q <= (clr_q == AW'(HIST_DEPTH - 1)) ? '0 : clr_q + 1'b1;
        end
        DP_LAT: begin
          if (next_rel_q <= last_rearm_q) begin
            wov_q <= wov_q + 32'd1;
          end
          if ($signed(diff64[31:0]) > wmax_q) wmax_q <= diff64[31:0];
          if ($signed(diff64[31:0]) < wmin_q) wmin_q <= diff64[31:0];
          wsum_q     <= wsum_q + {{32{diff64[31]}}, diff64[31:0]};
          next_rel_q <= next_rel_q + {33'd0, per};
        end
        DP_SK_MUL: begin
          wov_q <= wov_q + k_w;
        end
        DP_SK_ADD: begin
          next_rel_q <= next_rel_q + {1'b0, prod_q};
        end
        DP_COUNT: begin
          last_rearm_q <= in_q.rearm_time;
          sc_q         <= sts_o.close_win ? 20'd0 : sc_inc;
        end
        DP_CW_KEEP: begin
          kmin_q  <= mn_q;
          kmax_q  <= mx_q;
          kavg_q  <= kavg_n;
          if (mn_q < best_q) best_q <= mn_q;
          if (mx_q > worst_q) worst_q <= mx_q;
          acc_q   <= acc_q + {{32{kavg_n[31]}}, kavg_n};
          ovt_q   <= ovt_q + wov_q;
        end
        DP_CW_FIN: begin
          if (warm_q && loops_q == {16'd0, warmup_q}) begin
            loops_q <= 32'd1;
            warm_q  <= 1'b0;
          end else begin
            loops_q <= loops_q + 32'd1;
          end
          wmin_q <= INIT_MIN;
          wmax_q <= INIT_MAX;
          wsum_q <= '0;
          wov_q  <= '0;
          kind_q <= KIND_INTERIM;
        end
        default: ;
      endcase
    end
  end

  // Working payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_CAPTURE:  in_q <= in_data_i;
      DP_LAT:      dt_q <= diff64[31:0];
      DP_CVT_NS: begin
        case (cmd_i.job)
          JOB_SUM: sumns_q <= sp;
          JOB_MAX: begin
            ns_q <= sat32(sp);
            mx_q <= sat32(sp);
          end
          JOB_MIN: begin
            ns_q <= sat32(sp);
            mn_q <= sat32(sp);
          end
          default: ns_q <= sat32(sp);
        endcase
      end
      DP_BIN_RD:   bin_q   <= bin_full[AW-1:0];
      DP_SK_MUL:   prod_q  <= {31'd0, k_w} * {32'd0, per};
      DP_STOP_FIN: savg_q  <= kavg_n;
      DP_RESP:     out_q   <= resp;
      DP_RD_CAP: begin
        if (!rd_ok) begin
          cnt_q <= '0;
        end else begin
          case (in_q.hist_select)
            HSEL_MIN: cnt_q <= rd_min;
            HSEL_MAX: cnt_q <= rd_max;
            default:  cnt_q <= rd_avg;
          endcase
        end
      end
      default: ;
    endcase
    // Latch the sign of the divider operand
    case (cmd_i.op)
      DP_DIV_CVT:  neg_q <= src_v[63];
      DP_DIV_AVG:  neg_q <= sumns_q[63];
      DP_DIV_STOP: neg_q <= acc_q[63];
      default: ;
    endcase
  end

  // Build the result for the current item
  always_comb begin
    resp      = '0;
    resp.kind = kind_q;
    case (kind_q) inside
      KIND_INTERIM, KIND_FINAL: begin
        resp.last_min_ns    = kmin_q;
        resp.last_max_ns    = kmax_q;
        resp.last_avg_ns    = kavg_q;
        resp.overall_min_ns = best_q;
        resp.overall_max_ns = worst_q;
        resp.total_overruns = ovt_q;
        resp.report_loops   = loops_q;
        if (kind_q == KIND_FINAL) resp.overall_avg_ns = savg_q;
      end
      KIND_COUNT: resp.hist_count = cnt_q;
      default: ;
    endcase
  end

  always_comb begin
    sts_o.item      = in_data_i.op;
    sts_o.div_busy  = div_busy;
    sts_o.out_free  = !out_valid_q || out_ready_i;
    sts_o.hist_on   = (used != 32'd0);
    sts_o.in_warmup = warm_q;
    sts_o.skip      = (dt_q > 32'sd0) && ($unsigned(dt_q) > {1'b0, per});
    sts_o.close_win = (sc_inc >= spr_nz) || (sc_inc == 20'd0);
    sts_o.clr_last  = (clr_q == AW'(HIST_DEPTH - 1));
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/tls_ctrl.sv @@
module tls_ctrl import tls_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

`include "timer_latency_statistics_defines.svh"

  typedef enum logic [27:0] {
    S_INIT      = 28'b1 << 0,
    S_IDLE      = 28'b1 << 1,
    S_CLEAR     = 28'b1 << 2,
    S_LAT       = 28'b1 << 3,
    S_CVT_GO    = 28'b1 << 4,
    S_CVT_WAIT  = 28'b1 << 5,
    S_CVT_NS    = 28'b1 << 6,
    S_BIN_GO    = 28'b1 << 7,
    S_BIN_WAIT  = 28'b1 << 8,
    S_BIN_RD    = 28'b1 << 9,
    S_BIN_WR    = 28'b1 << 10,
    S_SK_CHK    = 28'b1 << 11,
    S_SK_GO     = 28'b1 << 12,
    S_SK_WAIT   = 28'b1 << 13,
    S_SK_MUL    = 28'b1 << 14,
    S_SK_ADD    = 28'b1 << 15,
    S_COUNT     = 28'b1 << 16,
    S_CW_START  = 28'b1 << 17,
    S_AVG_GO    = 28'b1 << 18,
    S_AVG_WAIT  = 28'b1 << 19,
    S_CW_KEEP   = 28'b1 << 20,
    S_CW_FIN    = 28'b1 << 21,
    S_STOP_GO   = 28'b1 << 22,
    S_STOP_WAIT = 28'b1 << 23,
    S_STOP_FIN  = 28'b1 << 24,
    S_RD        = 28'b1 << 25,
    S_RD_WAIT   = 28'b1 << 26,
    S_RESP      = 28'b1 << 27
  } state_e;

  state_e state_q, state_d;
  job_e   job_q, job_d;
  logic   div_go;

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    cmd_o.op   = DP_NONE;
    cmd_o.job  = job_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      // Sweep the histograms after reset
      S_INIT: begin
        cmd_o.op = DP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_CAPTURE;
          case (sts_i.item)
            ITEM_START:  state_d = S_CLEAR;
            ITEM_SAMPLE: state_d = S_LAT;
            ITEM_STOP:   state_d = S_STOP_GO;
            default:     state_d = S_RD;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (sts_i.clr_last) state_d = S_RESP;
      end
      S_LAT: begin
        cmd_o.op = DP_LAT;
        job_d    = JOB_DT;
        state_d  = (sts_i.hist_on && !sts_i.in_warmup) ? S_CVT_GO : S_SK_CHK;
      end
      // Convert cycles to nanoseconds
      S_CVT_GO: begin
        cmd_o.op = DP_DIV_CVT;
        state_d  = S_CVT_WAIT;
      end
      S_CVT_WAIT: begin
        if (!sts_i.div_busy) state_d = S_CVT_NS;
      end
      S_CVT_NS: begin
        cmd_o.op = DP_CVT_NS;
        case (job_q)
          JOB_DT:  state_d = S_BIN_GO;
          JOB_MAX: begin
            if (sts_i.hist_on) begin
              state_d = S_BIN_GO;
            end else begin
              job_d   = JOB_MIN;
              state_d = S_CVT_GO;
            end
          end
          JOB_MIN: begin
            if (sts_i.hist_on) begin
              state_d = S_BIN_GO;
            end else begin
              job_d   = JOB_SUM;
              state_d = S_CVT_GO;
            end
          end
          default: state_d = S_AVG_GO;
        endcase
      end
      // Bin a nanosecond value into its histogram
      S_BIN_GO: begin
        cmd_o.op = DP_DIV_BIN;
        state_d  = S_BIN_WAIT;
      end
      S_BIN_WAIT: begin
        if (!sts_i.div_busy) state_d = S_BIN_RD;
      end
      S_BIN_RD: begin
        cmd_o.op = DP_BIN_RD;
        state_d  = S_BIN_WR;
      end
      S_BIN_WR: begin
        cmd_o.op = DP_BIN_WR;
        case (job_q)
          JOB_DT:  state_d = S_SK_CHK;
          JOB_MAX: begin
            job_d   = JOB_MIN;
            state_d = S_CVT_GO;
          end
          default: begin
            job_d   = JOB_SUM;
            state_d = S_CVT_GO;
          end
        endcase
      end
      // Account for skipped periods
      S_SK_CHK: begin
        state_d = sts_i.skip ? S_SK_GO : S_COUNT;
      end
      S_SK_GO: begin
        cmd_o.op = DP_DIV_SKIP;
        state_d  = S_SK_WAIT;
      end
      S_SK_WAIT: begin
        if (!sts_i.div_busy) state_d = S_SK_MUL;
      end
      S_SK_MUL: begin
        cmd_o.op = DP_SK_MUL;
        state_d  = S_SK_ADD;
      end
      S_SK_ADD: begin
        cmd_o.op = DP_SK_ADD;
        state_d  = S_COUNT;
      end
      S_COUNT: begin
        cmd_o.op = DP_COUNT;
        state_d  = sts_i.close_win ? S_CW_START : S_RESP;
      end
      // Close the window
      S_CW_START: begin
        if (sts_i.in_warmup) begin
          state_d = S_CW_FIN;
        end else begin
          job_d   = JOB_MAX;
          state_d = S_CVT_GO;
        end
      end
      S_AVG_GO: begin
        cmd_o.op = DP_DIV_AVG;
        state_d  = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (!sts_i.div_busy) state_d = S_CW_KEEP;
      end
      S_CW_KEEP: begin
        cmd_o.op = DP_CW_KEEP;
        state_d  = S_CW_FIN;
      end
      S_CW_FIN: begin
        cmd_o.op = DP_CW_FIN;
        state_d  = S_RESP;
      end
      // Overall average for the final report
      S_STOP_GO: begin
        cmd_o.op = DP_DIV_STOP;
        state_d  = S_STOP_WAIT;
      end
      S_STOP_WAIT: begin
        if (!sts_i.div_busy) state_d = S_STOP_FIN;
      end
      S_STOP_FIN: begin
        cmd_o.op = DP_STOP_FIN;
        state_d  = S_RESP;
      end
      // Histogram read
      S_RD: begin
        cmd_o.op = DP_RD;
        state_d  = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        cmd_o.op = DP_RD_CAP;
        state_d  = S_RESP;
      end
      // Hand the result to the output register
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.op = DP_RESP;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      job_q   <= JOB_DT;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
    end
  end

  assign div_go = (cmd_o.op == DP_DIV_CVT) || (cmd_o.op == DP_DIV_BIN) ||
                  (cmd_o.op == DP_DIV_SKIP) || (cmd_o.op == DP_DIV_AVG) ||
                  (cmd_o.op == DP_DIV_STOP);

  `TLS_ASSERT(a_div_free, div_go |-> !sts_i.div_busy, "divider started while busy")
  `TLS_ASSERT_NEXT(a_div_runs, div_go, sts_i.div_busy, "divider did not start")
  `TLS_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "second item taken")

endmodule
